@@ src/kst_pkg.sv @@
// Package for the keyed score table: payload structs, opcodes, status codes,
// sequencer states and sizing constants. No dependencies.
`timescale 1ns / 1ps

package kst_pkg;

    localparam int MAX_PLAYERS = 16;
    localparam int IDX_W       = $clog2(MAX_PLAYERS);
    localparam int CNT_W       = $clog2(MAX_PLAYERS + 1);
    localparam int SUM_W       = 32 + CNT_W;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_UPDATE = 3'd2,
        OP_MAX    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_SORT   = 3'd5,
        OP_AVG    = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SORT_RD,
        S_SORT_CMP,
        S_DIV,
        S_LIST,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] player_id;
        logic signed [31:0] score_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_id;
        logic signed [31:0] result_score;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } div_rsp_t;

endpackage

@@ src/keyed_score_table_core.sv @@
// Top level of the keyed score table: record memory, sequencer, shared compare unit.
// Depends on kst_pkg and kst_divider.
// Sequence per operation: clear, and add to an empty or full table, go straight to the
// response; add shifts the records up; update, max and remove scan (remove then shifts
// down); average scans, then divides; sort does an insertion sort, then lists the records.
// One item at a time; the next is taken once the last result has transferred.
// Reset (rst_n async low) empties the table; record storage is not cleared.
`timescale 1ns / 1ps

module keyed_score_table_core
    import kst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [31:0] ids_mem    [MAX_PLAYERS];
    logic [31:0] scores_mem [MAX_PLAYERS];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] sidx_reg, sidx_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [2:0]       op_reg, op_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      val_reg, val_next;
    logic signed [31:0] bsc_reg, bsc_next;
    logic [31:0]      bid_reg, bid_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic             ov_reg, ov_next;
    out_item_t        od_reg, od_next;

    logic             we;
    logic [IDX_W-1:0] wa;
    logic [31:0]      wid, wsc;
    logic [31:0]      rid, rsc;
    logic             cmp_gt;
    logic [IDX_W-1:0] last_idx;
    div_req_t         dreq;
    div_rsp_t         drsp;

    kst_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign rid      = ids_mem[idx_reg];
    assign rsc      = scores_mem[idx_reg];
    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign cmp_gt   = $signed(op_reg == OP_SORT ? rsc : bsc_reg)
                    > $signed(op_reg == OP_SORT ? val_reg : rsc);

    function automatic out_item_t mk(status_t s, logic [31:0] i, logic [31:0] c, logic l);
        out_item_t o;
        o.status       = s;
        o.result_id    = i;
        o.result_score = c;
        o.last_of_run  = l;
        return o;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sidx_next  = sidx_reg;
        best_next  = best_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        bsc_next   = bsc_reg;
        bid_next   = bid_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        we         = 1'b0;
        wa         = idx_reg;
        wid        = rid;
        wsc        = rsc;
        dreq.start    = 1'b0;
        dreq.dividend = sum_reg;
        dreq.divisor  = count_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    op_next  = in_data.op;
                    key_next = in_data.player_id;
                    val_next = in_data.score_value;
                    idx_next = '0;
                    sum_next = '0;
                    bsc_next = 32'sh8000_0000;
                    od_next  = mk(ST_OK, '0, '0, 1'b1);
                    state_next = S_RESP;
                    case (in_data.op)
                        OP_CLEAR: count_next = '0;
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_PLAYERS))
                                od_next = mk(ST_FULL, '0, '0, 1'b1);
                            else if (count_reg == '0)
                            begin
                                we = 1'b1; wa = '0;
                                wid = in_data.player_id; wsc = in_data.score_value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                idx_next   = last_idx;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_UPDATE, OP_MAX, OP_REMOVE, OP_AVG, OP_SORT:
                        begin
                            if (count_reg == '0)
                                od_next = mk(ST_EMPTY, '0, '0, 1'b1);
                            else if (in_data.op == OP_SORT)
                            begin
                                if (count_reg == CNT_W'(1))
                                    state_next = S_LIST;
                                else
                                begin
                                    sidx_next  = IDX_W'(1);
                                    idx_next   = IDX_W'(1);
                                    state_next = S_SORT_RD;
                                end
                            end
                            else
                                state_next = S_SCAN;
                        end
                        OP_NONE: state_next = S_IDLE;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                state_next = S_RESP;
                if (op_reg == OP_MAX)
                begin
                    if (idx_reg == '0 || cmp_gt == 1'b0 && $signed(rsc) > bsc_reg)
                    begin
                        bsc_next = rsc;
                        bid_next = rid;
                    end
                    if (idx_reg != last_idx) begin idx_next = idx_reg + 1'b1; state_next = S_SCAN; end
                    else if (idx_reg == '0 || $signed(rsc) > bsc_reg)
                        od_next = mk(ST_OK, rid, rsc, 1'b1);
                    else
                        od_next = mk(ST_OK, bid_reg, bsc_reg, 1'b1);
                end
                else if (op_reg == OP_AVG)
                begin
                    sum_next = sum_reg + SUM_W'($signed(rsc));
                    if (idx_reg != last_idx) begin idx_next = idx_reg + 1'b1; state_next = S_SCAN; end
                    else state_next = S_DIV;
                end
                else if (rid == key_reg)
                begin
                    if (op_reg == OP_UPDATE)
                    begin
                        we = 1'b1; wsc = val_reg;
                    end
                    else if (idx_reg == last_idx)
                        count_next = count_reg - 1'b1;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SHIFT_DOWN;
                    end
                end
                else if (idx_reg == last_idx)
                    od_next = mk(ST_NOTFOUND, '0, '0, 1'b1);
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SHIFT_UP:
            begin
                we = 1'b1; wa = idx_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_SORT_CMP;
                    op_next    = OP_ADD;
                end
                else
                    idx_next = idx_reg - 1'b1;
            end
            S_SHIFT_DOWN:
            begin
                we = 1'b1; wa = idx_reg - 1'b1;
                if (idx_reg == last_idx)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_SORT_RD:
            begin
                key_next  = rid;
                val_next  = rsc;
                idx_next  = idx_reg - 1'b1;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (op_reg == OP_ADD)
                begin
                    we = 1'b1; wa = '0; wid = key_reg; wsc = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else if (cmp_gt)
                begin
                    we = 1'b1; wa = idx_reg + 1'b1;
                    if (idx_reg == '0)
                    begin
                        we = 1'b1;
                        state_next = S_SORT_CMP;
                        op_next = OP_NONE;
                    end
                    else
                        idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    we = 1'b1; wa = idx_reg + 1'b1; wid = key_reg; wsc = val_reg;
                    state_next = S_SORT_RD;
                    if (sidx_reg == last_idx) begin idx_next = '0; state_next = S_LIST; end
                    else begin sidx_next = sidx_reg + 1'b1; idx_next = sidx_reg + 1'b1; end
                end
                if (op_reg == OP_NONE)
                begin
                    we = 1'b1; wa = '0; wid = key_reg; wsc = val_reg;
                    op_next = OP_SORT;
                    state_next = S_SORT_RD;
                    if (sidx_reg == last_idx) begin idx_next = '0; state_next = S_LIST; end
                    else begin sidx_next = sidx_reg + 1'b1; idx_next = sidx_reg + 1'b1; end
                end
            end
            S_DIV:
            begin
                if (op_reg == OP_AVG)
                begin
                    dreq.start = 1'b1;
                    op_next    = OP_CLEAR;
                end
                else if (drsp.done)
                begin
                    od_next    = mk(ST_OK, '0, drsp.quotient, 1'b1);
                    state_next = S_RESP;
                end
            end
            S_LIST:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = mk(ST_OK, rid, rsc, idx_reg == last_idx);
                    if (idx_reg == last_idx) state_next = S_IDLE;
                    else idx_next = idx_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sidx_reg <= sidx_next;
        best_reg <= best_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        bsc_reg  <= bsc_next;
        bid_reg  <= bid_next;
        sum_reg  <= sum_next;
        od_reg   <= od_next;
        if (we)
        begin
            ids_mem[wa]    <= wid;
            scores_mem[wa] <= wsc;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

@@ src/kst_divider.sv @@
// Restoring divider, one quotient bit per cycle, signed truncating toward zero.
// Depends on kst_pkg.
`timescale 1ns / 1ps

module kst_divider
    import kst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] den_reg, den_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] qs;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        mag       = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        trial     = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            neg_next  = req.dividend[SUM_W-1];
            quo_next  = mag;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign qs           = neg_reg ? SUM_W'(-quo_reg) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = qs[31:0];

endmodule

@@ src/kst_checker.sv @@
// Port-level checker for the keyed score table, bound to the top level.
// Depends on kst_pkg.
`timescale 1ns / 1ps

module kst_checker
    import kst_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op != OP_NONE |=> !in_ready)
        else $error("accepted two items back to back");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.last_of_run)
        else $error("error status not final");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.result_id == 0)
        else $error("error result carries an id");

endmodule

bind keyed_score_table_core kst_checker u_kst_checker (.*);

@@ tb/sv/keyed_score_table_checker.sv @@
// Checker for the keyed score table: watches both channels, predicts each result
// from its own copy of the table and compares. Depends on kst_pkg.
`timescale 1ns / 1ps

module keyed_score_table_checker
    import kst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    logic signed [31:0] table_ids [MAX_PLAYERS];
    logic signed [31:0] table_scores [MAX_PLAYERS];
    int                 table_len;
    out_item_t          expected_q [$];

    function automatic out_item_t make_result(status_t st, logic signed [31:0] rid,
                                              logic signed [31:0] rsc, logic last);
        out_item_t r;
        r.status       = st;
        r.result_id    = rid;
        r.result_score = rsc;
        r.last_of_run  = last;
        return r;
    endfunction

    task automatic predict_table_op(input in_item_t item);
        int                 pos;
        int                 best;
        int                 j;
        logic signed [31:0] kid;
        logic signed [31:0] ksc;
        logic signed [63:0] sum;
        logic signed [63:0] avg;
        pos = -1;
        case (op_t'(item.op))
            OP_CLEAR:
            begin
                table_len = 0;
                expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
            end
            OP_ADD:
            begin
                if (table_len >= MAX_PLAYERS)
                    expected_q.push_back(make_result(ST_FULL, 0, 0, 1'b1));
                else
                begin
                    for (int i = table_len; i > 0; i--)
                    begin
                        table_ids[i]    = table_ids[i-1];
                        table_scores[i] = table_scores[i-1];
                    end
                    table_ids[0]    = item.player_id;
                    table_scores[0] = item.score_value;
                    table_len++;
                    expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
                end
            end
            OP_UPDATE, OP_REMOVE:
            begin
                if (table_len == 0)
                    expected_q.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                else
                begin
                    for (int i = table_len - 1; i >= 0; i--)
                        if (table_ids[i] == item.player_id)
                            pos = i;
                    if (pos < 0)
                        expected_q.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
                    else
                    begin
                        if (op_t'(item.op) == OP_UPDATE)
                            table_scores[pos] = item.score_value;
                        else
                        begin
                            for (int i = pos; i + 1 < table_len; i++)
                            begin
                                table_ids[i]    = table_ids[i+1];
                                table_scores[i] = table_scores[i+1];
                            end
                            table_len--;
                        end
                        expected_q.push_back(make_result(ST_OK, 0, 0, 1'b1));
                    end
                end
            end
            OP_MAX:
            begin
                if (table_len == 0)
                    expected_q.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                else
                begin
                    best = 0;
                    for (int i = 1; i < table_len; i++)
                        if (table_scores[i] > table_scores[best])
                            best = i;
                    expected_q.push_back(make_result(ST_OK, table_ids[best],
                                                     table_scores[best], 1'b1));
                end
            end
            OP_SORT:
            begin
                if (table_len == 0)
                    expected_q.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                else
                begin
                    for (int i = 1; i < table_len; i++)
                    begin
                        kid = table_ids[i];
                        ksc = table_scores[i];
                        j = i;
                        while (j > 0 && table_scores[j-1] > ksc)
                        begin
                            table_ids[j]    = table_ids[j-1];
                            table_scores[j] = table_scores[j-1];
                            j--;
                        end
                        table_ids[j]    = kid;
                        table_scores[j] = ksc;
                    end
                    for (int i = 0; i < table_len; i++)
                        expected_q.push_back(make_result(ST_OK, table_ids[i],
                                                         table_scores[i],
                                                         i + 1 == table_len));
                end
            end
            OP_AVG:
            begin
                if (table_len == 0)
                    expected_q.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                else
                begin
                    sum = 0;
                    for (int i = 0; i < table_len; i++)
                        sum += 64'(table_scores[i]);
                    avg = sum / 64'(table_len);
                    expected_q.push_back(make_result(ST_OK, 0, avg[31:0], 1'b1));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            table_len = 0;
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (out_data.status !== exp_item.status
                        || out_data.result_id !== exp_item.result_id
                        || out_data.result_score !== exp_item.result_score
                        || out_data.last_of_run !== exp_item.last_of_run)
                    begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %p actual %p",
                                     exp_item, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_table_op(in_data);
        end
    end

endmodule

@@ tb/sv/keyed_score_table_core_tb.sv @@
// Testbench top for the keyed score table: clock, reset, directed and random
// operation stimulus, output stalls and verdict. Depends on kst_pkg, the core and
// keyed_score_table_checker.
`timescale 1ns / 1ps

module keyed_score_table_core_tb;
    import kst_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    bit        long_hold;
    logic signed [31:0] id_pool [8];

    keyed_score_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    keyed_score_table_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send_op(input op_t op, input logic signed [31:0] pid,
                           input logic signed [31:0] sc);
        in_item_t item;
        item.op          = op;
        item.player_id   = pid;
        item.score_value = sc;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic gap_or_burst(inout int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_score();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 7) << 16);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_ADD;
        if (r < 50) return OP_UPDATE;
        if (r < 62) return OP_REMOVE;
        if (r < 72) return OP_MAX;
        if (r < 82) return OP_AVG;
        if (r < 90) return OP_SORT;
        if (r < 95) return OP_CLEAR;
        return OP_NONE;
    endfunction

    // receiver: random stalls, one long hold-off once long_hold is raised
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) < 65);
    end

    initial
    begin
        long_hold = 1'b0;
        #(12 * 300);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int burst_left;
        int wait_cycles;
        logic signed [31:0] pid;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        burst_left = 0;
        foreach (id_pool[i])
            id_pool[i] = $signed($urandom);
        id_pool[0] = 32'sh7fffffff;
        id_pool[1] = 32'sh80000000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, ties, fill to full, not found, unused code
        send_op(OP_MAX, 0, 0);
        send_op(OP_UPDATE, 1, 1);
        send_op(OP_REMOVE, 1, 1);
        send_op(OP_SORT, 0, 0);
        send_op(OP_AVG, 0, 0);
        send_op(OP_NONE, 32'shffffffff, 32'shffffffff);
        send_op(OP_ADD, 32'sh7fffffff, 32'sh7fffffff);
        send_op(OP_ADD, 32'sh80000000, 32'sh80000000);
        send_op(OP_ADD, 5, 32'sh7fffffff);
        send_op(OP_MAX, 0, 0);
        send_op(OP_AVG, 0, 0);
        for (int i = 0; i < 14; i++)
            send_op(OP_ADD, i, 32'sh7fffffff - i);
        send_op(OP_UPDATE, 99, 0);
        send_op(OP_REMOVE, 99, 0);
        send_op(OP_UPDATE, 5, 32'sh80000000);
        send_op(OP_SORT, 0, 0);
        send_op(OP_AVG, 0, 0);
        send_op(OP_REMOVE, 32'sh7fffffff, 0);
        send_op(OP_CLEAR, 0, 0);

        // random: ids mostly from a small pool so updates and removes hit
        for (int n = 0; n < 330; n++)
        begin
            gap_or_burst(burst_left);
            pid = ($urandom_range(0, 4) == 0) ? $signed($urandom)
                                              : id_pool[$urandom_range(0, 7)];
            send_op(pick_op(), pid, pick_score());
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
